// File: hdl/bst_pkg.sv
package bst_pkg;

    localparam int CFG_W = 12;
    localparam int DIM_W = 14;
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int MIN_DIM = 4;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd480;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [3:0] COUNT_MIN = 4'd2;
    localparam logic [3:0] COUNT_MAX = 4'd6;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PASS = 2'd2;

    typedef struct packed {
        logic frame_last;
        logic pixel_out;
    } bst_result_t;

    function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_W-1:0] v, logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] ve;
        ve = DIM_W'(v);
        if (ve < DIM_W'(MIN_DIM)) begin
            return DIM_W'(MIN_DIM);
        end else if (ve > hi) begin
            return hi;
        end
        return ve;
    endfunction

    // window: bits 0..2 right column, 3..5 middle, 6..8 left; top, mid, bottom
    function automatic logic delete_center(logic [8:0] w, logic sel);
        logic [8:0] ring;
        logic [3:0] steps;
        logic [3:0] cnt;
        logic m1;
        logic m2;
        ring = {w[3], w[6], w[7], w[8], w[5], w[2], w[1], w[0], w[3]};
        steps = '0;
        cnt = '0;
        for (int k = 0; k < 8; k++) begin
            if (!ring[k] && ring[k+1]) begin
                steps = steps + 4'd1;
            end
            cnt = cnt + 4'(ring[k]);
        end
        if (!sel) begin
            m1 = ring[0] & ring[2] & ring[4];
            m2 = ring[2] & ring[4] & ring[6];
        end else begin
            m1 = ring[0] & ring[2] & ring[6];
            m2 = ring[0] & ring[4] & ring[6];
        end
        return (steps == 4'd1) && (cnt >= COUNT_MIN) && (cnt <= COUNT_MAX) && !m1 && !m2;
    endfunction

endpackage

// File: hdl/bst_line_mem.sv
module bst_line_mem #(
    parameter int DEPTH = bst_pkg::MAX_WIDTH_DEF,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [1:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [1:0]    wr_data
);

    // bit 0 upper line, bit 1 middle line
    logic [1:0] mem [DEPTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/bst_out_fifo.sv
module bst_out_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bst_pkg::bst_result_t push_data,
    output logic [1:0]          count,
    output logic                m_tvalid,
    input  logic                m_tready,
    output bst_pkg::bst_result_t m_data
);

    localparam int DEPTH = 3;

    bst_pkg::bst_result_t buf_reg [DEPTH];
    logic [1:0] head_reg;
    logic [1:0] tail_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop = m_tvalid && m_tready;
    assign m_tvalid = count_reg != 2'd0;
    assign m_data = buf_reg[head_reg];
    assign count = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[tail_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                tail_reg <= (tail_reg == 2'(DEPTH - 1)) ? 2'd0 : tail_reg + 2'd1;
            end
            if (pop) begin
                head_reg <= (head_reg == 2'(DEPTH - 1)) ? 2'd0 : head_reg + 2'd1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < 2'(DEPTH) || pop))
        else $error("result buffer overflow");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(DEPTH))
        else $error("result buffer count out of range");

endmodule

// File: hdl/binary_skeleton_thinning_pass.sv
// One Zhang-Suen thinning sub-pass over a binary image streamed in raster order.
// Input beats: s_tdata[0] is the pixel, s_tuser is the command (pixel or drain).
// A drain beat sent while pixels of the frame are still due is taken and dropped.
// After the last pixel, each beat, drain or pixel (read as 0), flushes one result;
// width+1 such beats finish the frame, whose final result carries m_tlast.
// Output beats: m_tdata[0] is the thinned pixel, m_tlast marks the frame end.
// Results lag the input by one row plus one pixel; the first width+1 pixels of a
// frame give no result. Border pixels pass through unchanged.
// Throughput is one beat per clock while s_tready is high. Each pixel reads its
// column from a 2-bit wide line memory at accept and writes it back the next cycle,
// with a forward path for back-to-back hits on the same column. A pixel passes the
// stage-1 register and then the result buffer before its result is offered on m_.
// A 3-entry result buffer absorbs the pipeline when m_tready is low; s_tready drops
// once the buffer and the stage in flight hold three results between them.
// Reset clears counters, window and buffer and loads width 480, height 480, first
// sub-pass; line memory contents are don't-care until written.
// Configuration writes take effect on the next beat and belong between frames.
module binary_skeleton_thinning_pass #(
    parameter int MAX_WIDTH = bst_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bst_pkg::MAX_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] pixel_in, [7:1] zero
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] pixel_out, [7:1] zero
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_wdata
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int HCW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT) + 2;

    logic [bst_pkg::CFG_W-1:0] cfg_width_reg;
    logic [bst_pkg::CFG_W-1:0] cfg_height_reg;
    logic                      cfg_pass_reg;

    logic [WCW-1:0] w_dim;
    logic [HCW-1:0] h_dim;

    logic [CW-1:0] in_col_reg;
    logic [RW-1:0] in_row_reg;
    logic [CW-1:0] out_col_reg;
    logic [RW-1:0] out_row_reg;

    logic acc;
    logic complete;
    logic ignore;
    logic go;
    logic pix;
    logic emit;
    logic in_wrap;
    logic out_wrap;
    logic row_end;
    logic border;
    logic last;

    logic          v1_reg;
    logic [CW-1:0] addr1_reg;
    logic          pix1_reg;
    logic          emit1_reg;
    logic          border1_reg;
    logic          last1_reg;

    logic          fwd_valid_reg;
    logic [CW-1:0] fwd_addr_reg;
    logic [1:0]    fwd_data_reg;

    logic [1:0] rd_data;
    logic [1:0] col_data;
    logic [2:0] column_bits;
    logic [1:0] wr_data;
    logic [8:0] window_reg;
    logic [8:0] window_next;
    logic       center;
    logic       result;
    logic       push;

    bst_pkg::bst_result_t push_data;
    bst_pkg::bst_result_t m_data;
    logic [1:0]           fifo_count;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg <= bst_pkg::WIDTH_RESET;
            cfg_height_reg <= bst_pkg::HEIGHT_RESET;
            cfg_pass_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bst_pkg::REG_WIDTH: cfg_width_reg <= cfg_wdata;
                bst_pkg::REG_HEIGHT: cfg_height_reg <= cfg_wdata;
                bst_pkg::REG_PASS: cfg_pass_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign w_dim = WCW'(bst_pkg::clamp_dim(cfg_width_reg, bst_pkg::DIM_W'(MAX_WIDTH)));
    assign h_dim = HCW'(bst_pkg::clamp_dim(cfg_height_reg, bst_pkg::DIM_W'(MAX_HEIGHT)));

    // stage 0: counters, memory read
    assign s_tready = (3'(fifo_count) + 3'(v1_reg && emit1_reg)) <= 3'd2;
    assign acc = s_tvalid && s_tready;
    assign complete = in_row_reg >= RW'(h_dim);
    assign ignore = !complete && (s_tuser == bst_pkg::CMD_DRAIN);
    assign go = acc && !ignore;
    assign pix = complete ? 1'b0 : s_tdata[0];
    assign emit = (in_row_reg >= RW'(2)) || (in_row_reg == RW'(1) && in_col_reg != '0);
    assign in_wrap = ((CW+1)'(in_col_reg) + (CW+1)'(1)) >= (CW+1)'(w_dim);
    assign out_wrap = ((CW+1)'(out_col_reg) + (CW+1)'(1)) >= (CW+1)'(w_dim);
    assign row_end = (out_row_reg + RW'(1)) >= RW'(h_dim);
    assign border = (out_row_reg == '0) || row_end || (out_col_reg == '0) || out_wrap;
    assign last = row_end && out_wrap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (go) begin
            if (emit && last) begin
                in_col_reg <= '0;
                in_row_reg <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else begin
                if (in_wrap) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + RW'(1);
                end else begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
                if (emit) begin
                    if (out_wrap) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + RW'(1);
                    end else begin
                        out_col_reg <= out_col_reg + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= go;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            addr1_reg <= in_col_reg;
            pix1_reg <= pix;
            emit1_reg <= emit;
            border1_reg <= border;
            last1_reg <= last;
        end
    end

    bst_line_mem #(
        .DEPTH(MAX_WIDTH),
        .AW(CW)
    ) u_line_mem (
        .aclk(aclk),
        .rd_en(go),
        .rd_addr(in_col_reg),
        .rd_data(rd_data),
        .wr_en(v1_reg),
        .wr_addr(addr1_reg),
        .wr_data(wr_data)
    );

    // stage 1: window update, decision, write back
    assign col_data = (fwd_valid_reg && fwd_addr_reg == addr1_reg) ? fwd_data_reg : rd_data;
    assign column_bits = {pix1_reg, col_data[1], col_data[0]};
    assign wr_data = {pix1_reg, col_data[1]};
    assign window_next = {window_reg[5:0], column_bits};
    assign center = window_next[4];
    assign result = border1_reg ? center
                  : (center && !bst_pkg::delete_center(window_next, cfg_pass_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end else if (v1_reg) begin
            window_reg <= window_next;
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            fwd_addr_reg <= addr1_reg;
            fwd_data_reg <= wr_data;
        end
    end

    assign push = v1_reg && emit1_reg;
    assign push_data.pixel_out = result;
    assign push_data.frame_last = last1_reg;

    bst_out_fifo u_out_fifo (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(push),
        .push_data(push_data),
        .count(fifo_count),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_data(m_data)
    );

    assign m_tdata = {7'd0, m_data.pixel_out};
    assign m_tlast = m_data.frame_last;

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && (fifo_count >= 2'd2 || (v1_reg && emit1_reg))))
        else $error("input stalled without pending results");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && emit && last) |=> (in_col_reg == '0 && in_row_reg == '0
                                  && out_col_reg == '0 && out_row_reg == '0))
        else $error("counters not cleared after frame end");

    a_stage_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && ignore) |=> !v1_reg)
        else $error("early drain beat reached the pipeline");

endmodule

// File: tb/tb_binary_skeleton_thinning_pass.sv
module tb_binary_skeleton_thinning_pass;

    localparam int MODE_RANDOM = 0;
    localparam int MODE_DENSE = 1;
    localparam int MODE_BLOCK = 2;
    localparam int MODE_FIXED = 3;

    class pixel_scoreboard;
        bit                        upper_row [bst_pkg::MAX_WIDTH_DEF];
        bit                        middle_row [bst_pkg::MAX_WIDTH_DEF];
        bit [8:0]                  window;
        int unsigned               in_col;
        int unsigned               in_row;
        int unsigned               out_col;
        int unsigned               out_row;
        logic [bst_pkg::CFG_W-1:0] width_reg;
        logic [bst_pkg::CFG_W-1:0] height_reg;
        bit                        pass_sel;
        bst_pkg::bst_result_t      expected_q[$];
        int                        errors;
        int                        checked;

        function new();
            width_reg = bst_pkg::WIDTH_RESET;
            height_reg = bst_pkg::HEIGHT_RESET;
            pass_sel = 1'b0;
            window = '0;
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            errors = 0;
            checked = 0;
        endfunction

        function int unsigned fit_dim(logic [bst_pkg::CFG_W-1:0] v, int unsigned hi);
            if (v < bst_pkg::MIN_DIM) return bst_pkg::MIN_DIM;
            if (v > hi) return hi;
            return v;
        endfunction

        // ring index 0 is north, going clockwise
        function bit thin_hit(bit [8:0] win, bit sel);
            bit [7:0] ring;
            int       steps;
            ring = {win[6], win[7], win[8], win[5], win[2], win[1], win[0], win[3]};
            steps = 0;
            for (int k = 0; k < 8; k++) begin
                if (!ring[k] && ring[(k + 1) % 8]) steps++;
            end
            if (steps != 1 || $countones(ring) < 2 || $countones(ring) > 6) return 1'b0;
            if (!sel) return !(ring[0] & ring[2] & ring[4]) && !(ring[2] & ring[4] & ring[6]);
            return !(ring[0] & ring[2] & ring[6]) && !(ring[0] & ring[4] & ring[6]);
        endfunction

        function void note_beat(logic cmd, logic pix);
            int unsigned          w;
            int unsigned          h;
            int unsigned          col;
            bit                   p;
            bit                   emit;
            bit                   res;
            bit                   last_px;
            bit [2:0]             column_bits;
            bst_pkg::bst_result_t item;
            w = fit_dim(width_reg, bst_pkg::MAX_WIDTH_DEF);
            h = fit_dim(height_reg, bst_pkg::MAX_HEIGHT_DEF);
            p = pix;
            if (in_row < h && cmd == bst_pkg::CMD_DRAIN) return;
            if (in_row >= h) p = 1'b0;
            emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
            col = in_col % bst_pkg::MAX_WIDTH_DEF;
            column_bits = {p, middle_row[col], upper_row[col]};
            upper_row[col] = middle_row[col];
            middle_row[col] = p;
            window = {window[5:0], column_bits};
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (!emit) return;
            if (out_row == 0 || out_row + 1 >= h || out_col == 0 || out_col + 1 >= w) begin
                res = window[4];
            end else begin
                res = window[4] && !thin_hit(window, pass_sel);
            end
            last_px = (out_row + 1 >= h) && (out_col + 1 >= w);
            item.frame_last = last_px;
            item.pixel_out = res;
            expected_q = {expected_q, item};
            if (last_px) begin
                in_col = 0;
                in_row = 0;
                out_col = 0;
                out_row = 0;
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
        endfunction

        function void check_beat(logic pix, logic last);
            bst_pkg::bst_result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected beat, pixel_out %b frame_last %b", $time, pix, last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (want.pixel_out !== pix) begin
                $display("%0t: pixel_out expected %b actual %b", $time, want.pixel_out, pix);
                errors++;
            end
            if (want.frame_last !== last) begin
                $display("%0t: frame_last expected %b actual %b", $time, want.frame_last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = bst_pkg::CMD_PIXEL;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = bst_pkg::REG_WIDTH;
    logic [11:0] cfg_wdata = '0;

    pixel_scoreboard board = new();
    int  beats_sent = 0;
    int  small_items = 0;
    int  ignored_drains = 0;
    int  late_pixels = 0;
    int  frames = 0;
    int  holds = 0;
    bit  sender_idles = 1'b1;

    binary_skeleton_thinning_pass i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    task automatic send_beat(input logic cmd, input logic pix);
        while (sender_idles && $urandom_range(0, 99) < 17) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, pix};
        s_tuser <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_beat(cmd, pix);
        beats_sent++;
        sender_idles = beats_sent < 300 || beats_sent >= 600;
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [11:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        case (index)
            bst_pkg::REG_WIDTH: board.width_reg = value;
            bst_pkg::REG_HEIGHT: board.height_reg = value;
            bst_pkg::REG_PASS: board.pass_sel = value[0];
            default: ;
        endcase
    endtask

    task automatic run_frame(input logic [11:0] wreg, input logic [11:0] hreg,
                             input logic pass, input int mode, input logic [15:0] pattern);
        int unsigned w;
        int unsigned h;
        int unsigned r0;
        int unsigned r1;
        int unsigned c0;
        int unsigned c1;
        logic        pix;
        logic        inside_block;
        write_reg(bst_pkg::REG_WIDTH, wreg);
        write_reg(bst_pkg::REG_HEIGHT, hreg);
        write_reg(bst_pkg::REG_PASS, {11'd0, pass});
        cfg_wr_en <= 1'b0;
        w = board.fit_dim(wreg, bst_pkg::MAX_WIDTH_DEF);
        h = board.fit_dim(hreg, bst_pkg::MAX_HEIGHT_DEF);
        r0 = $urandom_range(0, h - 1);
        r1 = $urandom_range(r0, h - 1);
        c0 = $urandom_range(0, w - 1);
        c1 = $urandom_range(c0, w - 1);
        for (int unsigned r = 0; r < h; r++) begin
            for (int unsigned c = 0; c < w; c++) begin
                if ((mode == MODE_FIXED) ? (r == 0 && c == 0) : ($urandom_range(0, 99) < 3)) begin
                    send_beat(bst_pkg::CMD_DRAIN, 1'($urandom_range(0, 1)));
                    ignored_drains++;
                end
                inside_block = r >= r0 && r <= r1 && c >= c0 && c <= c1;
                case (mode)
                    MODE_RANDOM: pix = 1'($urandom_range(0, 1));
                    MODE_DENSE: pix = $urandom_range(0, 99) < 75;
                    MODE_BLOCK: pix = inside_block ^ ($urandom_range(0, 99) < 4);
                    default: pix = pattern[(r * 4 + c) % 16];
                endcase
                send_beat(bst_pkg::CMD_PIXEL, pix);
                if (mode != MODE_FIXED && w * h < 4096) small_items++;
            end
        end
        // tail flush, some beats arrive as pixels past the frame end
        for (int unsigned i = 0; i <= w; i++) begin
            if ((mode == MODE_FIXED) ? (i == 1) : ($urandom_range(0, 99) < 15)) begin
                send_beat(bst_pkg::CMD_PIXEL, 1'($urandom_range(0, 1)));
                late_pixels++;
            end else begin
                send_beat(bst_pkg::CMD_DRAIN, 1'($urandom_range(0, 1)));
            end
            if (mode != MODE_FIXED && w * h < 4096) small_items++;
        end
        s_tvalid <= 1'b0;
        frames++;
        while (board.expected_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    function automatic logic [11:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return 12'($urandom_range(0, 3));
            1: return 12'($urandom_range(13, 40));
            default: return 12'($urandom_range(4, 12));
        endcase
    endfunction

    initial begin
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                board.check_beat(m_tdata[0], m_tlast);
                if (board.checked == 150 || board.checked == 900 || board.checked == 5000) begin
                    m_tready <= 1'b0;
                    repeat (100) @(posedge aclk);
                    holds++;
                end
            end
            if (board.checked >= 250 && board.checked < 550) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= $urandom_range(0, 99) >= 17;
            end
        end
    end

    initial begin
        int n;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_frame(12'd3, 12'd0, 1'b1, MODE_FIXED, 16'h6EE6);
        n = 0;
        while (small_items < 1200 || n <= 7) begin
            if (n == 3) begin
                run_frame(12'd40, 12'd4, 1'b0, MODE_BLOCK, '0);
            end else if (n == 7) begin
                run_frame(12'd4, 12'd40, 1'b1, MODE_RANDOM, '0);
            end else begin
                run_frame(pick_dim(), pick_dim(), 1'($urandom_range(0, 1)),
                          int'($urandom_range(MODE_RANDOM, MODE_BLOCK)), '0);
            end
            n++;
        end
        repeat (10) @(posedge aclk);
        if (board.expected_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, board.expected_q.size());
        end
        $display("ran %0d frames in both sub-passes, sizes below the minimum up to 40x40", frames);
        $display("%0d beats, %0d early drains, %0d late pixels, %0d results, %0d hold-offs",
                 beats_sent, ignored_drains, late_pixels, board.checked, holds);
        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("tb_binary_skeleton_thinning_pass: PASS");
        end else begin
            $display("tb_binary_skeleton_thinning_pass: FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("%0t: timeout", $time);
        $display("tb_binary_skeleton_thinning_pass: FAIL");
        $finish;
    end

endmodule
